### src/mtg_pkg.sv
`default_nettype none
package mtg_pkg;
  localparam int unsigned N = 624;
  localparam int unsigned M = 397;
  localparam int unsigned AW = 10;
  localparam logic [31:0] DEFAULT_SEED = 32'd4357;
  localparam logic [31:0] SEED_MULT = 32'd69069;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [AW-1:0] POS_USED = AW'(N);
  localparam logic [AW-1:0] POS_UNSEEDED = AW'(N + 1);

  function automatic logic [31:0] temper(input logic [31:0] w_in);
    logic [31:0] w;
    w = w_in;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & 32'h9d2c5680);
    w = w ^ ((w << 15) & 32'hefc60000);
    w = w ^ (w >> 18);
    return w;
  endfunction
endpackage
`default_nettype wire

### src/mtg_core.sv
`default_nettype none
// Front part: owns the state memory; seeds, twists, and emits tempered words
// plus the modulus into the queue.
module mtg_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [31:0] cfg_seed_i,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic [31:0] req_modulus_i,
  output logic             word_valid_o,
  input  wire logic        word_ready_i,
  output logic [31:0]      word_o,
  output logic [31:0]      word_modulus_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_TW_A = 3'd2;  // read word i
  localparam logic [2:0] S_TW_B = 3'd3;  // read word i+1
  localparam logic [2:0] S_TW_C = 3'd4;  // read word i+M, compute, write
  localparam logic [2:0] S_READ = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [31:0] mem [mtg_pkg::N];
  logic [2:0]  state_q, state_d;
  logic [mtg_pkg::AW-1:0] pos_q, pos_d, idx_q, idx_d;
  logic [31:0] seed_q, prev_q, prev_d, wa_q, wb_q, rdata_q, mod_q, word_q;
  logic [mtg_pkg::AW-1:0] raddr;
  logic        we;
  logic [mtg_pkg::AW-1:0] waddr;
  logic [31:0] wdata, mix, twisted;
  logic [mtg_pkg::AW-1:0] idx_nxt, idx_far;

  always_comb begin
    idx_nxt = (idx_q == mtg_pkg::AW'(mtg_pkg::N - 1)) ? '0 : idx_q + 1'b1;
    if (idx_q >= mtg_pkg::AW'(mtg_pkg::N - mtg_pkg::M))
      idx_far = idx_q - mtg_pkg::AW'(mtg_pkg::N - mtg_pkg::M);
    else
      idx_far = idx_q + mtg_pkg::AW'(mtg_pkg::M);
    mix = {wa_q[31], wb_q[30:0]};
    twisted = rdata_q ^ (mix >> 1) ^ (mix[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
  end

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    idx_d = idx_q;
    prev_d = prev_q;
    raddr = idx_q;
    we = 1'b0;
    waddr = idx_q;
    wdata = prev_q;
    case (state_q)
      S_IDLE: begin
        // word 0 is prefetched when a twist comes next
        raddr = (pos_q >= mtg_pkg::POS_USED) ? '0 : pos_q;
        if (req_valid_i) begin
          if (pos_q == mtg_pkg::POS_UNSEEDED) begin
            state_d = S_SEED;
            idx_d = '0;
            prev_d = seed_q;
          end else if (pos_q == mtg_pkg::POS_USED) begin
            state_d = S_TW_A;
            idx_d = '0;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_SEED: begin
        we = 1'b1;
        prev_d = prev_q * mtg_pkg::SEED_MULT;
        if (idx_q == mtg_pkg::AW'(mtg_pkg::N - 1)) begin
          state_d = S_TW_A;
          idx_d = '0;
          raddr = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TW_A: begin
        raddr = idx_nxt;
        state_d = S_TW_B;
      end
      S_TW_B: begin
        raddr = idx_far;
        state_d = S_TW_C;
      end
      S_TW_C: begin
        we = 1'b1;
        wdata = twisted;
        if (idx_q == mtg_pkg::AW'(mtg_pkg::N - 1)) begin
          pos_d = '0;
          raddr = '0;
          state_d = S_READ;
        end else begin
          idx_d = idx_nxt;
          raddr = idx_nxt;
          state_d = S_TW_A;
        end
      end
      S_READ: begin
        raddr = pos_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (word_ready_i) begin
          pos_d = pos_q + 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_valid_i) pos_d = mtg_pkg::POS_UNSEEDED;
  end

  // S_TW_A is entered with the read of word i already issued.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q <= mtg_pkg::POS_UNSEEDED;
      seed_q <= mtg_pkg::DEFAULT_SEED;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      if (cfg_valid_i) seed_q <= cfg_seed_i;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    prev_q <= prev_d;
    if (state_q == S_TW_A) wa_q <= rdata_q;
    if (state_q == S_TW_B) wb_q <= rdata_q;
    if (state_q == S_IDLE && req_valid_i) mod_q <= req_modulus_i;
    if (state_q == S_READ) word_q <= mtg_pkg::temper(rdata_q);
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign word_valid_o = (state_q == S_OUT);
  assign word_o = word_q;
  assign word_modulus_o = mod_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= mtg_pkg::POS_UNSEEDED) else $error("read position out of range");
  a_out_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_o |-> pos_q < mtg_pkg::POS_USED) else $error("word emitted from bad position");
  a_cfg_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> pos_q == mtg_pkg::POS_UNSEEDED) else $error("seed write not marked");
endmodule
`default_nettype wire

### src/mtg_fifo.sv
`default_nettype none
// Two-entry queue of word/modulus pairs.
module mtg_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      out_data_o
);
  logic [63:0] mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("queue pointers disagree");
  a_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 && !pop |=> cnt_q == 2'd2) else $error("full queue lost an entry");
endmodule
`default_nettype wire

### src/mtg_divider.sv
`default_nettype none
// Back part: restoring divider, one quotient bit per cycle, output register.
module mtg_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]  state_q;
  logic [31:0] dvd_q, div_q, rem_q;
  logic [4:0]  cnt_q;
  logic [32:0] trial;

  assign trial = {rem_q, dvd_q[31]} - {1'b0, div_q};
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign value_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          state_q <= (in_data_i[31:0] == 32'd0) ? S_OUT : S_DIV;
          cnt_q <= '0;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 5'd31) state_q <= S_OUT;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // rem_q carries the raw word when the modulus is zero
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      dvd_q <= in_data_i[63:32];
      div_q <= in_data_i[31:0];
      rem_q <= (in_data_i[31:0] == 32'd0) ? in_data_i[63:32] : 32'd0;
    end else if (state_q == S_DIV) begin
      dvd_q <= {dvd_q[30:0], 1'b0};
      if (!trial[32]) rem_q <= trial[31:0];
      else rem_q <= {rem_q[30:0], dvd_q[31]};
    end
  end

  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < div_q) else $error("partial remainder too large");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == 5'd31 |=> state_q == S_OUT) else $error("divide overran");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(value_o)) else $error("result changed");
endmodule
`default_nettype wire

### src/mersenne_twister_generator.sv
`default_nettype none
// MT19937 generator, 1998 seeding (x[i] = 69069 * x[i-1]). One request in,
// one 32-bit value out: the tempered word, or its remainder by modulus when
// modulus is nonzero. A draw with a nonzero modulus passes through the
// 32-step bit-serial divider; with a zero modulus the divider loads the word
// straight into its output register. The word generator and divider run
// decoupled through a two-entry queue. One draw in every 624 first
// regenerates the state, stepping through S_TW_A, S_TW_B and S_TW_C for each
// word, as the state memory has a single read port. The first draw after
// reset or after a seed write also refills the memory from the seed.
// Write the seed only while the block is idle.
module mersenne_twister_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_seed_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] modulus_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      value_o
);
  logic        w_valid, w_ready, d_valid, d_ready;
  logic [31:0] w_word, w_mod;
  logic [63:0] d_data;

  assign cfg_ready_o = 1'b1;

  mtg_core u_core (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_seed_i,
    .req_valid_i(in_valid_i), .req_ready_o(in_ready_o), .req_modulus_i(modulus_i),
    .word_valid_o(w_valid), .word_ready_i(w_ready),
    .word_o(w_word), .word_modulus_o(w_mod)
  );

  mtg_fifo u_fifo (
    .clk_i, .rst_ni,
    .in_valid_i(w_valid), .in_ready_o(w_ready), .in_data_i({w_word, w_mod}),
    .out_valid_o(d_valid), .out_ready_i(d_ready), .out_data_o(d_data)
  );

  mtg_divider u_div (
    .clk_i, .rst_ni,
    .in_valid_i(d_valid), .in_ready_o(d_ready), .in_data_i(d_data),
    .out_valid_o, .out_ready_i, .value_o
  );
endmodule
`default_nettype wire

### dv/tb_mersenne_twister_generator.sv
`timescale 1ns / 1ps
module tb_mersenne_twister_generator;

  // Predicts each drawn value and holds the values still owed by the block.
  class draw_scoreboard;
    logic [31:0] words[mtg_pkg::N];
    int unsigned pos;
    logic [31:0] seed_reg;
    logic [31:0] pending_values[$];
    int unsigned errors;

    function new();
      seed_reg = mtg_pkg::DEFAULT_SEED;
      pos = mtg_pkg::N + 1;
      errors = 0;
    endfunction

    function void set_seed(logic [31:0] s);
      seed_reg = s;
      pos = mtg_pkg::N + 1;
    endfunction

    function logic [31:0] shape(logic [31:0] w_in);
      logic [31:0] w;
      w = w_in;
      w ^= w >> 11;
      w ^= (w << 7) & 32'h9d2c5680;
      w ^= (w << 15) & 32'hefc60000;
      w ^= w >> 18;
      return w;
    endfunction

    function void regenerate();
      logic [31:0] mix;
      logic [31:0] r;
      if (pos == mtg_pkg::N + 1) begin
        words[0] = seed_reg;
        for (int i = 1; i < mtg_pkg::N; i++) words[i] = mtg_pkg::SEED_MULT * words[i-1];
      end
      for (int i = 0; i < mtg_pkg::N; i++) begin
        mix = (words[i] & 32'h80000000) | (words[(i+1)%mtg_pkg::N] & 32'h7fffffff);
        r = words[(i+mtg_pkg::M)%mtg_pkg::N] ^ (mix >> 1);
        if (mix[0]) r ^= mtg_pkg::TWIST_MATRIX;
        words[i] = r;
      end
      pos = 0;
    endfunction

    function void note_request(logic [31:0] modulus);
      logic [31:0] w;
      if (pos >= mtg_pkg::N) regenerate();
      w = shape(words[pos]);
      pos++;
      if (modulus != 0) w = w % modulus;
      pending_values.push_back(w);
    endfunction

    function void check_value(logic [31:0] got);
      logic [31:0] exp_v;
      if (pending_values.size() == 0) begin
        $error("value: unexpected transaction, actual %h", got);
        errors++;
        return;
      end
      exp_v = pending_values.pop_front();
      if (got !== exp_v) begin
        $error("value: expected %h actual %h", exp_v, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [31:0] cfg_seed_i;
  logic in_valid_i, in_ready_o;
  logic [31:0] modulus_i;
  logic out_valid_o, out_ready_i;
  logic [31:0] value_o;

  mersenne_twister_generator dut (.*);

  draw_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  int unsigned hold_cycles;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: stall decided at each falling edge, result taken at rising edge.
  initial begin
    out_ready_i = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready_i <= 0;
      end else
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && out_ready_i) sb.check_value(value_o);

  // valid stays up into the next transaction unless the sender idles
  task automatic send_draw(logic [31:0] modulus);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    modulus_i <= modulus;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(modulus);
    @(negedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] s);
    in_valid_i <= 0;
    while (sb.pending_values.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_seed_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_seed(s);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic logic [31:0] pick_modulus();
    case ($urandom_range(5))
      0: return 0;
      1: return $urandom_range(1, 16);
      2: return $urandom;
      3: return 32'hffffffff - $urandom_range(3);
      4: return 32'h1 << $urandom_range(31);
      default: return $urandom_range(1, 100000);
    endcase
  endfunction

  initial begin
    sb = new();
    rst_ni = 0;
    cfg_valid_i = 0; cfg_seed_i = 0;
    in_valid_i = 0; modulus_i = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: default seed, then seeds 0 and ffffffff, extremes of modulus
    send_draw(0);
    send_draw(1);
    send_draw(2);
    send_draw(32'hffffffff);
    send_draw(32'h80000000);
    send_draw(32'h7fffffff);
    send_draw(32'h55555555);
    send_draw(32'haaaaaaaa);
    send_draw(3);
    write_seed(0);
    send_draw(0);
    send_draw(7);
    write_seed(32'hffffffff);
    send_draw(0);
    send_draw(32'hffffffff);

    // back-pressure: hold receiver while requests keep coming
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) send_draw(pick_modulus());

    // random phases; together they run past one full regeneration
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (ph == 0) write_seed($urandom);
      for (int i = 0; i < 157; i++) send_draw(pick_modulus());
    end

    in_valid_i <= 0;
    while (sb.pending_values.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_values.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
